// File: sv/quadrature_encoder_bank_assert.svh
// Assertion macros for the quadrature encoder bank checks.
// Each macro expects signals named clk and arst_n in scope.
`ifndef QUADRATURE_ENCODER_BANK_ASSERT_SVH
`define QUADRATURE_ENCODER_BANK_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define QEB_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qeb check failed");

// Next-cycle implication, disabled while in reset
`define QEB_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qeb check failed");

`endif

// File: sv/qeb_pkg.sv
package qeb_pkg;

	localparam int PAIR_W     = 2;
	localparam int COUNT_W    = 8;
	localparam int PIN_W      = 8;
	// number of count fields in one result item
	localparam int OUT_FIELDS = 4;

	typedef logic [PAIR_W-1:0]         pair_t;
	typedef logic signed [COUNT_W-1:0] count_t;

	// pin pair codes
	localparam pair_t PAIR_00 = 2'b00;
	localparam pair_t PAIR_01 = 2'b01;
	localparam pair_t PAIR_10 = 2'b10;
	localparam pair_t PAIR_11 = 2'b11;

	// saturation limits
	localparam count_t COUNT_MAX = 8'sd64;
	localparam count_t COUNT_MIN = -8'sd64;

	// per-lane control for one accepted item
	typedef struct packed {
		logic apply;
		logic clear;
	} lane_ctl_t;

endpackage

// File: sv/qeb_in_if.sv
interface qeb_in_if import qeb_pkg::*; ();

	logic               valid;
	logic               ready;
	logic [PIN_W-1:0]   encoder_pins;
	logic               clear_counts;

	modport source (output valid, output encoder_pins, output clear_counts, input ready);
	modport sink (input valid, input encoder_pins, input clear_counts, output ready);

endinterface

// File: sv/qeb_out_if.sv
interface qeb_out_if import qeb_pkg::*; ();

	logic   valid;
	logic   ready;
	count_t count_enc0;
	count_t count_enc1;
	count_t count_enc2;
	count_t count_enc3;

	modport source (output valid, output count_enc0, output count_enc1,
		output count_enc2, output count_enc3, input ready);
	modport sink (input valid, input count_enc0, input count_enc1,
		input count_enc2, input count_enc3, output ready);

endinterface

// File: sv/qeb_lane.sv
// One encoder: pair history and saturating detent count.
module qeb_lane import qeb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  lane_ctl_t ctl,
	input  pair_t     pair,
	output count_t    count_next
);

	pair_t  prev_q;
	pair_t  earlier_q;
	count_t count_q;

	logic   changed;
	logic   step_up;
	logic   step_down;
	count_t base;

	// sequence match against earlier / previous / current pairs
	always_comb begin
		changed   = (pair != prev_q);
		step_up   = (earlier_q == PAIR_00 && prev_q == PAIR_01 && pair == PAIR_11) ||
		            (earlier_q == PAIR_11 && prev_q == PAIR_10 && pair == PAIR_00);
		step_down = (earlier_q == PAIR_00 && prev_q == PAIR_10 && pair == PAIR_11) ||
		            (earlier_q == PAIR_11 && prev_q == PAIR_01 && pair == PAIR_00);
		base      = ctl.clear ? '0 : count_q;
		count_next = base;
		if (changed && step_up) begin
			if (base != COUNT_MAX)
				count_next = base + count_t'(1);
		end else if (changed && step_down) begin
			if (base != COUNT_MIN)
				count_next = base - count_t'(1);
		end
	end

	// state update on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= PAIR_00;
			earlier_q <= PAIR_00;
			count_q   <= '0;
		end else if (ctl.apply) begin
			prev_q  <= pair;
			count_q <= count_next;
			if (changed)
				earlier_q <= prev_q;
		end
	end

endmodule

// File: sv/qeb_merge.sv
// Handshake control and result register collecting the lane counts.
module qeb_merge import qeb_pkg::*; #(
	parameter int NUM_LANES = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	qeb_in_if.sink          samples,
	output lane_ctl_t       ctl,
	input  count_t          lane_count [NUM_LANES],
	qeb_out_if.source       counts
);

	logic   valid_q;
	count_t field_q [OUT_FIELDS];
	count_t field_d [OUT_FIELDS];
	logic   accept;

	// new item may enter whenever the result register frees up this cycle
	assign samples.ready = !valid_q || counts.ready;
	assign accept        = samples.valid && samples.ready;
	assign ctl.apply     = accept;
	assign ctl.clear     = samples.clear_counts;

	// absent encoders report zero
	for (genvar j = 0; j < OUT_FIELDS; j++) begin : g_field
		if (j < NUM_LANES) begin : g_used
			assign field_d[j] = lane_count[j];
		end else begin : g_absent
			assign field_d[j] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (counts.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			field_q <= field_d;
	end

	assign counts.valid      = valid_q;
	assign counts.count_enc0 = field_q[0];
	assign counts.count_enc1 = field_q[1];
	assign counts.count_enc2 = field_q[2];
	assign counts.count_enc3 = field_q[3];

endmodule

// File: sv/quadrature_encoder_bank.sv
// The counts for an accepted pin sample are in the result register in the following cycle.
// Throughput: one item per cycle while the output is not stalled; lane counts are
// combinational and the result register takes a new item in the cycle its held item is taken.
// Reset (arst_n low, asynchronous): all pin pairs and counts go to zero and
// no result is held.
module quadrature_encoder_bank import qeb_pkg::*; #(
	parameter int NUM_ENCODERS = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	qeb_in_if.sink    samples,
	qeb_out_if.source counts
);

	lane_ctl_t ctl;
	count_t    lane_count [NUM_ENCODERS];

	// one lane per encoder; encoders past the pin field see pair zero
	for (genvar k = 0; k < NUM_ENCODERS; k++) begin : g_lane
		pair_t pair;
		if (k < OUT_FIELDS) begin : g_pin
			assign pair = samples.encoder_pins[PAIR_W*k +: PAIR_W];
		end else begin : g_nopin
			assign pair = PAIR_00;
		end

		qeb_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.pair       (pair),
			.count_next (lane_count[k])
		);
	end

	qeb_merge #(
		.NUM_LANES (NUM_ENCODERS)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.ctl        (ctl),
		.lane_count (lane_count),
		.counts     (counts)
	);

endmodule

// File: sv/qeb_checker.sv
`include "quadrature_encoder_bank_assert.svh"

// Port-level checks for the encoder bank.
module qeb_checker import qeb_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	qeb_in_if.sink    samples,
	qeb_out_if.source counts
);

	logic             in_acc;
	logic             out_stall;
	logic             in_range;
	logic             all_zero;
	logic             clear_rpt;
	logic             acc_q;
	logic [PIN_W-1:0] pins_q;

	assign in_acc    = samples.valid && samples.ready;
	assign out_stall = counts.valid && !counts.ready;

	// every reported count inside the saturation limits
	assign in_range = counts.count_enc0 >= COUNT_MIN && counts.count_enc0 <= COUNT_MAX &&
		counts.count_enc1 >= COUNT_MIN && counts.count_enc1 <= COUNT_MAX &&
		counts.count_enc2 >= COUNT_MIN && counts.count_enc2 <= COUNT_MAX &&
		counts.count_enc3 >= COUNT_MIN && counts.count_enc3 <= COUNT_MAX;

	assign all_zero = counts.count_enc0 == '0 && counts.count_enc1 == '0 &&
		counts.count_enc2 == '0 && counts.count_enc3 == '0;

	// previous cycle's accept and pins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= 1'b0;
			pins_q <= '0;
		end else begin
			acc_q  <= in_acc;
			pins_q <= samples.encoder_pins;
		end
	end

	// clear item right behind an item with the same pins
	assign clear_rpt = in_acc && acc_q && samples.clear_counts &&
		samples.encoder_pins == pins_q;

	// a held result stays up while stalled
	`QEB_ASSERT_NXT(a_hold_valid, out_stall, counts.valid)

	// a result only appears after an accepted item
	`QEB_ASSERT_IMP(a_rise_from_item, $rose(counts.valid), $past(in_acc))

	// counts stay within the saturation limits
	`QEB_ASSERT_IMP(a_count_range, counts.valid, in_range)

	// clear with unchanged pins right after the previous item gives all zeros
	`QEB_ASSERT_NXT(a_clear_zero, clear_rpt, all_zero)

endmodule

bind quadrature_encoder_bank qeb_checker u_qeb_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.samples (samples),
	.counts  (counts)
);
